// ----- rtl/rws_pkg.sv -----
// Shared codes and types for the roulette wheel selector.
package rws_pkg;

  localparam int KIND_W  = 2;
  localparam int FIT_W   = 16;
  localparam int ID_W    = 16;
  localparam int FRAC_W  = 16;
  localparam int GAP_W   = 8;

  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

  localparam logic [GAP_W-1:0] GAP_RESET = 8'd1;

  // Status part of the draw token that walks the cell chain.
  typedef struct packed {
    logic            valid;
    logic            found;
    logic [ID_W-1:0] id;
  } tok_ctl_t;

endpackage

// ----- rtl/rws_if.sv -----
// Request and response channel interfaces.
interface rws_req_if;
  logic                          valid;
  logic                          ready;
  logic [rws_pkg::KIND_W-1:0]    kind;
  logic [rws_pkg::FIT_W-1:0]     fitness;
  logic [rws_pkg::ID_W-1:0]      entry_id;
  logic [rws_pkg::FRAC_W-1:0]    random_fraction;

  modport source (output valid, kind, fitness, entry_id, random_fraction, input ready);
  modport sink   (input valid, kind, fitness, entry_id, random_fraction, output ready);
endinterface

interface rws_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [rws_pkg::ID_W-1:0]  selected_id;
  logic                      found;

  modport source (output valid, selected_id, found, input ready);
  modport sink   (input valid, selected_id, found, output ready);
endinterface

// ----- rtl/rws_cell.sv -----
// One wheel cell: holds one interval and checks the passing draw token.
module rws_cell #(
  parameter int IDX     = 0,
  parameter int BOUND_W = 23,
  parameter int COUNT_W = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  // load port
  input  logic                       ld_en,
  input  logic [COUNT_W-1:0]         ld_index,
  input  logic [BOUND_W-1:0]         ld_lower,
  input  logic [BOUND_W-1:0]         ld_upper,
  input  logic [rws_pkg::ID_W-1:0]   ld_id,
  // number of loaded entries
  input  logic [COUNT_W-1:0]         count,
  // token from the previous cell
  input  rws_pkg::tok_ctl_t          ctl_in,
  input  logic [BOUND_W-1:0]         v_in,
  // token to the next cell
  output rws_pkg::tok_ctl_t          ctl_out,
  output logic [BOUND_W-1:0]         v_out
);

  logic [BOUND_W-1:0]       lower;
  logic [BOUND_W-1:0]       upper;
  logic [rws_pkg::ID_W-1:0] id;
  logic                     hit;

  always_ff @(posedge clk) begin
    if (ld_en && ld_index == COUNT_W'(IDX)) begin
      lower <= ld_lower;
      upper <= ld_upper;
      id    <= ld_id;
    end
  end

  // first hit in load order wins: later cells see found already set
  assign hit = !ctl_in.found && (COUNT_W'(IDX) < count) &&
               (v_in >= lower) && (v_in < upper);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    // data holds after the token passes, so the tail keeps the result
    if (ctl_in.valid) begin
      ctl_out.found <= ctl_in.found | hit;
      ctl_out.id    <= hit ? id : ctl_in.id;
      v_out         <= v_in;
    end
  end

endmodule

// ----- rtl/roulette_wheel_selector_top.sv -----
// Roulette wheel selector top level: control, scaling and the cell chain.
//
//  channel   dir  signals                                        moves
//  req       in   valid/ready, kind, fitness, entry_id, rnd frac clear, load or draw
//  rsp       out  valid/ready, selected_id, found                one per draw
//  cfg       in   cfg_we, cfg_data                               interval_gap write
//
// Clear and load complete when accepted. A draw steps through accept, scale
// multiply, inject, the token's pass through each cell of the chain, then the
// output load. req is ready only while no draw is in progress; the response
// register holds a result until taken, and a finished draw waits for it.
// rst is synchronous and empties the wheel; interval_gap resets to 1.
module roulette_wheel_selector_top #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  rws_req_if.sink                     req,
  rws_rsp_if.source                   rsp,
  input  logic                        cfg_we,
  input  logic [rws_pkg::GAP_W-1:0]   cfg_data
);

  localparam int BOUND_W = $clog2(MAX_ENTRIES) + 17;
  localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int PROD_W  = BOUND_W + rws_pkg::FRAC_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_INJ  = 3'd2;
  localparam logic [2:0] ST_RUN  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                  state;
  logic [rws_pkg::GAP_W-1:0]   gap;
  logic [COUNT_W-1:0]          count;
  logic [BOUND_W-1:0]          total;   // also the next lower bound
  logic [rws_pkg::FRAC_W-1:0]  frac;
  logic [BOUND_W-1:0]          v;
  logic [PROD_W-1:0]           prod;

  logic                        accept;
  logic                        ld_en;
  logic [BOUND_W-1:0]          ld_upper;
  logic                        rsp_free;

  rws_pkg::tok_ctl_t           ctl [0:MAX_ENTRIES];
  logic [BOUND_W-1:0]          tv  [0:MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]      tok_valids;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign ld_en     = accept && req.kind == rws_pkg::KIND_LOAD &&
                     count < COUNT_W'(MAX_ENTRIES);
  assign ld_upper  = total + BOUND_W'(req.fitness);
  assign prod      = PROD_W'(frac) * PROD_W'(total);
  assign rsp_free  = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= rws_pkg::GAP_RESET;
    end else if (cfg_we) begin
      gap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      total     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (state == ST_DONE && rsp_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.kind == rws_pkg::KIND_CLEAR) begin
              count <= '0;
              total <= '0;
            end else if (ld_en) begin
              count <= count + COUNT_W'(1);
              total <= ld_upper + BOUND_W'(gap);
            end else if (req.kind == rws_pkg::KIND_DRAW) begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL:  state <= ST_INJ;
        ST_INJ:  state <= ST_RUN;
        ST_RUN: begin
          if (ctl[MAX_ENTRIES].valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (rsp_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frac <= req.random_fraction;
    end
    if (state == ST_MUL) begin
      v <= prod[PROD_W-1:rws_pkg::FRAC_W];
    end
    if (state == ST_DONE && rsp_free) begin
      rsp.selected_id <= ctl[MAX_ENTRIES].id;
      rsp.found       <= ctl[MAX_ENTRIES].found;
    end
  end

  // token enters the head of the chain with nothing found
  assign ctl[0].valid = (state == ST_INJ);
  assign ctl[0].found = 1'b0;
  assign ctl[0].id    = '0;
  assign tv[0]        = v;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    rws_cell #(
      .IDX     (i),
      .BOUND_W (BOUND_W),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ld_en    (ld_en),
      .ld_index (count),
      .ld_lower (total),
      .ld_upper (ld_upper),
      .ld_id    (req.entry_id),
      .count    (count),
      .ctl_in   (ctl[i]),
      .v_in     (tv[i]),
      .ctl_out  (ctl[i+1]),
      .v_out    (tv[i+1])
    );
    assign tok_valids[i] = ctl[i+1].valid;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valids) <= 1)
    else $error("more than one draw token in the chain");

  a_tail_in_run: assert property (@(posedge clk) disable iff (rst)
    ctl[MAX_ENTRIES].valid |-> state == ST_RUN)
    else $error("token left the chain outside of a draw");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.found |-> rsp.selected_id == '0)
    else $error("miss result carries a nonzero id");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_DONE)
    else $error("response raised without a finished draw");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the roulette wheel selector: directed, full-wheel and random runs.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WHEEL_DEPTH = 64;
  localparam int SETTLE_CYCLES = WHEEL_DEPTH + 8;
  localparam int STALL_LIMIT = 5000;
  localparam logic [rws_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [rws_pkg::ID_W-1:0] id;
    logic                     found;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rws_pkg::GAP_W-1:0] cfg_data = '0;

  rws_req_if req_ch ();
  rws_rsp_if rsp_ch ();

  roulette_wheel_selector_top #(.MAX_ENTRIES(WHEEL_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Wheel predictor state
  logic [rws_pkg::GAP_W-1:0] gap_now = rws_pkg::GAP_RESET;
  int unsigned               wheel_count = 0;
  logic [31:0]               wheel_total = '0;
  logic [31:0]               wheel_next_lower = '0;
  logic [31:0]               wheel_lo [WHEEL_DEPTH];
  logic [31:0]               wheel_hi [WHEEL_DEPTH];
  logic [rws_pkg::ID_W-1:0]  wheel_tag [WHEEL_DEPTH];

  pick_t pending_picks[$];
  int    error_count = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    items_sent = 0;
  int    stall_cycles = 0;

  function automatic pick_t predict_draw(input logic [rws_pkg::FRAC_W-1:0] frac);
    pick_t       p;
    logic [63:0] scaled;
    p = '0;
    scaled = (64'(frac) * 64'(wheel_total)) >> 16;
    for (int k = 0; k < wheel_count; k++) begin
      if (scaled >= 64'(wheel_lo[k]) && scaled < 64'(wheel_hi[k])) begin
        p.id = wheel_tag[k];
        p.found = 1'b1;
        return p;
      end
    end
    return p;
  endfunction

  task automatic apply_to_wheel(input logic [rws_pkg::KIND_W-1:0] kind,
                                input logic [rws_pkg::FIT_W-1:0] fit,
                                input logic [rws_pkg::ID_W-1:0] id,
                                input logic [rws_pkg::FRAC_W-1:0] frac);
    case (kind)
      rws_pkg::KIND_CLEAR: begin
        wheel_count = 0;
        wheel_total = '0;
        wheel_next_lower = '0;
      end
      rws_pkg::KIND_LOAD: begin
        // loads past the last slot are dropped without a trace
        if (wheel_count < WHEEL_DEPTH) begin
          wheel_lo[wheel_count] = wheel_next_lower;
          wheel_hi[wheel_count] = wheel_next_lower + 32'(fit);
          wheel_tag[wheel_count] = id;
          wheel_next_lower = wheel_hi[wheel_count] + 32'(gap_now);
          wheel_total = wheel_total + 32'(fit) + 32'(gap_now);
          wheel_count++;
        end
      end
      rws_pkg::KIND_DRAW: pending_picks.push_back(predict_draw(frac));
      default: ;
    endcase
  endtask

  task automatic send_op(input logic [rws_pkg::KIND_W-1:0] kind,
                         input logic [rws_pkg::FIT_W-1:0] fit,
                         input logic [rws_pkg::ID_W-1:0] id,
                         input logic [rws_pkg::FRAC_W-1:0] frac);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.kind <= kind;
    req_ch.fitness <= fit;
    req_ch.entry_id <= id;
    req_ch.random_fraction <= frac;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_to_wheel(kind, fit, id, frac);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    // clear and load leave no result behind, so give the datapath time to drain
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_gap(input logic [rws_pkg::GAP_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    gap_now = value;
  endtask

  function automatic logic [rws_pkg::FIT_W-1:0] pick_fitness();
    case ($urandom_range(3))
      0: return rws_pkg::FIT_W'($urandom_range(15));
      1: return rws_pkg::FIT_W'($urandom_range(255));
      2: return rws_pkg::FIT_W'(16'hFFFF - $urandom_range(15));
      default: return rws_pkg::FIT_W'($urandom);
    endcase
  endfunction

  function automatic logic [rws_pkg::FRAC_W-1:0] pick_fraction();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return rws_pkg::FRAC_W'($urandom);
    endcase
  endfunction

  task automatic test_corner_cases();
    send_op(rws_pkg::KIND_DRAW, '0, '0, 16'hFFFF);        // empty wheel
    send_op(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(rws_pkg::KIND_LOAD, 16'h0000, 16'hFFFF, '0);  // zero fitness, never matches
    send_op(rws_pkg::KIND_LOAD, 16'hFFFF, 16'h0000, '0);
    send_op(rws_pkg::KIND_LOAD, 16'h0001, 16'hAAAA, '0);
    send_op(rws_pkg::KIND_LOAD, 16'd300, 16'h5555, '0);
    send_op(rws_pkg::KIND_DRAW, '0, '0, 16'h0000);        // lands before the first real interval
    send_op(rws_pkg::KIND_DRAW, '0, '0, 16'h0001);
    send_op(rws_pkg::KIND_DRAW, '0, '0, 16'h8000);
    send_op(rws_pkg::KIND_DRAW, '0, '0, 16'hFFFE);
    send_op(rws_pkg::KIND_DRAW, '0, '0, 16'hFFFF);
    send_op(rws_pkg::KIND_DRAW, 16'hFFFF, 16'hFFFF, 16'hFFF0);
    send_op(KIND_UNUSED, '0, '0, '0);
    send_op(rws_pkg::KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(rws_pkg::KIND_DRAW, '0, '0, 16'h7FFF);
    send_op(rws_pkg::KIND_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(rws_pkg::KIND_DRAW, '0, '0, 16'h0000);
    send_op(rws_pkg::KIND_DRAW, '0, '0, 16'hFFFF);        // trailing gap after the last interval
    send_op(rws_pkg::KIND_CLEAR, '0, '0, '0);
  endtask

  task automatic test_full_wheel();
    send_op(rws_pkg::KIND_CLEAR, '0, '0, '0);
    for (int k = 0; k < WHEEL_DEPTH + 3; k++)
      send_op(rws_pkg::KIND_LOAD, rws_pkg::FIT_W'($urandom_range(1, 255)),
              rws_pkg::ID_W'($urandom), '0);
    for (int k = 0; k < 8; k++)
      send_op(rws_pkg::KIND_DRAW, '0, '0, pick_fraction());
  endtask

  task automatic run_wheel_round();
    int n;
    if ($urandom_range(99) < 80) begin
      send_op(rws_pkg::KIND_CLEAR, rws_pkg::FIT_W'($urandom), rws_pkg::ID_W'($urandom),
              rws_pkg::FRAC_W'($urandom));
      n = ($urandom_range(11) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 8);
      for (int k = 0; k < n; k++)
        send_op(rws_pkg::KIND_LOAD, pick_fitness(), rws_pkg::ID_W'($urandom),
                rws_pkg::FRAC_W'($urandom));
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++)
        send_op(rws_pkg::KIND_DRAW, rws_pkg::FIT_W'($urandom), rws_pkg::ID_W'($urandom),
                pick_fraction());
    end else begin
      n = $urandom_range(1, 5);
      for (int k = 0; k < n; k++)
        send_op(rws_pkg::KIND_W'($urandom_range(3)), rws_pkg::FIT_W'($urandom),
                rws_pkg::ID_W'($urandom), rws_pkg::FRAC_W'($urandom));
    end
  endtask

  task automatic test_random_rounds();
    logic [rws_pkg::GAP_W-1:0] gaps [4];
    int sender_pct [4];
    int receiver_pct [4];
    int target;
    gaps = '{8'd0, 8'd255, rws_pkg::GAP_W'($urandom), rws_pkg::GAP_RESET};
    sender_pct = '{0, 50, 0, 8};
    receiver_pct = '{0, 0, 50, 8};
    for (int ph = 0; ph < 4; ph++) begin
      set_gap(gaps[ph]);
      send_idle_pct = sender_pct[ph];
      recv_stall_pct = receiver_pct[ph];
      target = items_sent + 110;
      while (items_sent < target) run_wheel_round();
    end
  endtask

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    pick_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected pick id %h found %b", $time,
                 rsp_ch.selected_id, rsp_ch.found);
        error_count++;
      end else begin
        want = pending_picks.pop_front();
        if (rsp_ch.selected_id !== want.id || rsp_ch.found !== want.found) begin
          $display("%0t: pick mismatch: expected id %h found %b, actual id %h found %b",
                   $time, want.id, want.found, rsp_ch.selected_id, rsp_ch.found);
          error_count++;
        end
      end
    end
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.kind = rws_pkg::KIND_CLEAR;
    req_ch.fitness = '0;
    req_ch.entry_id = '0;
    req_ch.random_fraction = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_cases();
    test_full_wheel();
    test_random_rounds();
    wait_idle();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rws_pkg.sv
rtl/rws_if.sv
rtl/rws_cell.sv
rtl/roulette_wheel_selector_top.sv
verif/tb.sv
